// ===== design/sqt_pkg.sv =====
// Package for the shell-style quoted word tokeniser.
// Holds the transfer payload types, character codes and line status codes.
// No dependencies.
`default_nettype none

package sqt_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Line status codes carried in line_kind.
  localparam logic [1:0] LK_TOKENS = 2'd0;
  localparam logic [1:0] LK_EMPTY  = 2'd1;
  localparam logic [1:0] LK_ERROR  = 2'd2;

  // Largest number of results that one input item can cause.
  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       word_end;
    logic       line_done;
    logic [1:0] line_kind;
    logic       last;
  } out_t;

endpackage

`default_nettype wire

// ===== design/shell_quote_tokenizer_top.sv =====
// Top level of the shell-style quoted word tokeniser.
// Depends on sqt_pkg for payload types and character codes.
//
// Usage: command-line bytes arrive on the input channel (in_valid_i,
// in_stall_o, in_data_i), one byte or end-only item per transfer. Word
// bytes, word ends and one line status result per line leave on the output
// channel (out_valid_o, out_stall_i, out_data_o), one result per transfer,
// with last set on the final result caused by each input item.
// Latency: results of an item are offered in the cycle after its transfer.
// Throughput: one item per cycle while each item causes at most one result and the receiver does not stall.
// An item that causes k results (at most three) holds the input channel until
// its last result leaves, because the output register drains one result per cycle.
// Items that cause no result only update the flags; they are stalled like any other item.
// Reset clears the quote, escape and word flags and empties the result
// buffer, so the first line after reset starts clean.
// When the receiver stalls, the current result stays on the output and the
// input is stalled once the buffer cannot take the next item's results.
`default_nettype none

module shell_quote_tokenizer_top
  import sqt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  // Parser flags.
  logic esc_q, esc_d;
  logic sq_q, sq_d;
  logic dq_q, dq_d;
  logic open_q, open_d;
  logic any_q, any_d;

  // Result buffer: slot 0 is the one on offer at the output.
  out_t       slot_q [MaxRes];
  out_t       slot_d [MaxRes];
  logic [1:0] cnt_q, cnt_d;

  // Results produced by the item at the input.
  out_t       res  [MaxRes];
  logic [1:0] nres;

  logic in_xfer;
  logic out_xfer;
  logic is_ws;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0];
  assign out_xfer    = out_valid_o && !out_stall_i;

  // The buffer can take a new item when it is empty or its last result is
  // leaving in this cycle.
  assign in_stall_o = (cnt_q > 2'd1) || ((cnt_q == 2'd1) && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign is_ws = (in_data_i.ch == CH_SPACE) ||
                 ((in_data_i.ch >= CH_TAB) && (in_data_i.ch <= CH_CR));

  // Tokeniser step: works out the next flags and the results of this item.
  always_comb begin
    out_t r_byte;
    out_t r_wend;
    out_t r_stat;
    r_byte = '0;
    r_byte.out_byte   = in_data_i.ch;
    r_byte.byte_valid = 1'b1;
    r_wend = '0;
    r_wend.word_end = 1'b1;
    r_stat = '0;
    r_stat.line_done = 1'b1;

    esc_d  = esc_q;
    sq_d   = sq_q;
    dq_d   = dq_q;
    open_d = open_q;
    any_d  = any_q;
    nres   = 2'd0;
    for (int i = 0; i < MaxRes; i++) begin
      res[i] = '0;
    end

    if (in_data_i.ch_valid) begin
      priority if (esc_q) begin
        res[nres] = r_byte;
        nres      = nres + 2'd1;
        open_d    = 1'b1;
        esc_d     = 1'b0;
      end else if (in_data_i.ch == CH_BACKSLASH) begin
        esc_d  = 1'b1;
        open_d = 1'b1;
      end else if (sq_q) begin
        if (in_data_i.ch == CH_SQUOTE) begin
          sq_d = 1'b0;
        end else begin
          res[nres] = r_byte;
          nres      = nres + 2'd1;
        end
        open_d = 1'b1;
      end else if (dq_q) begin
        if (in_data_i.ch == CH_DQUOTE) begin
          dq_d = 1'b0;
        end else begin
          res[nres] = r_byte;
          nres      = nres + 2'd1;
        end
        open_d = 1'b1;
      end else if (in_data_i.ch == CH_SQUOTE) begin
        sq_d   = 1'b1;
        open_d = 1'b1;
      end else if (in_data_i.ch == CH_DQUOTE) begin
        dq_d   = 1'b1;
        open_d = 1'b1;
      end else if (is_ws) begin
        if (open_q) begin
          res[nres] = r_wend;
          nres      = nres + 2'd1;
          open_d    = 1'b0;
          any_d     = 1'b1;
        end
      end else begin
        res[nres] = r_byte;
        nres      = nres + 2'd1;
        open_d    = 1'b1;
      end
    end

    if (in_data_i.line_end) begin
      // A backslash left dangling at line end becomes a word byte.
      if (esc_d) begin
        res[nres]          = r_byte;
        res[nres].out_byte = CH_BACKSLASH;
        nres               = nres + 2'd1;
      end
      if (sq_d || dq_d) begin
        // Unterminated quote: the open word is not closed.
        res[nres]           = r_stat;
        res[nres].line_kind = LK_ERROR;
        nres                = nres + 2'd1;
      end else begin
        if (open_d) begin
          res[nres] = r_wend;
          nres      = nres + 2'd1;
          any_d     = 1'b1;
        end
        res[nres]           = r_stat;
        res[nres].line_kind = any_d ? LK_TOKENS : LK_EMPTY;
        nres                = nres + 2'd1;
      end
      esc_d  = 1'b0;
      sq_d   = 1'b0;
      dq_d   = 1'b0;
      open_d = 1'b0;
      any_d  = 1'b0;
    end

    if (nres != 2'd0) begin
      res[nres - 2'd1].last = 1'b1;
    end
  end

  // Buffer control: load on an input transfer, otherwise shift on output.
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxRes; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (in_xfer) begin
      cnt_d = nres;
      for (int i = 0; i < MaxRes; i++) begin
        slot_d[i] = res[i];
      end
    end else if (out_xfer) begin
      cnt_d = cnt_q - 2'd1;
      for (int i = 0; i < MaxRes - 1; i++) begin
        slot_d[i] = slot_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      sq_q   <= 1'b0;
      dq_q   <= 1'b0;
      open_q <= 1'b0;
      any_q  <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        esc_q  <= esc_d;
        sq_q   <= sq_d;
        dq_q   <= dq_d;
        open_q <= open_d;
        any_q  <= any_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

`default_nettype wire

// ===== design/sqt_checker.sv =====
// Port-level checker for the shell-style quoted word tokeniser.
// Depends on sqt_pkg; bound to shell_quote_tokenizer_top below.
`default_nettype none

module sqt_checker
  import sqt_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // A stalled result stays on offer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // Every result is exactly one of byte, word end or line status.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({out_data_o.byte_valid, out_data_o.word_end,
                             out_data_o.line_done}))
    else $error("result kind not one-hot");

  // A line status closes the item's results and has a legal code.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_done |->
      out_data_o.last && ((out_data_o.line_kind == LK_TOKENS) ||
                          (out_data_o.line_kind == LK_EMPTY) ||
                          (out_data_o.line_kind == LK_ERROR)))
    else $error("bad line status result");

  // The input is only stalled while results are waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty buffer");

endmodule

bind shell_quote_tokenizer_top sqt_checker u_sqt_checker (.*);

`default_nettype wire
